// ===== hw/rtl/cesd_pkg.sv =====
// ----------------------------------------------------------------------------
// cesd_pkg: shared types and helpers for the C escape sequence decoder
// Holds the queue entry, status structs, character codes and small decode
// functions used by the front end, the queue, the back end and the top level.
// ----------------------------------------------------------------------------
package cesd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_X         = 8'h78;
  localparam logic [7:0] CHR_ONE       = 8'h31;
  localparam logic [7:0] CHR_SEVEN     = 8'h37;
  localparam logic [7:0] CHR_ZERO      = 8'h30;

  // One decoded result of one input byte: one or two output bytes.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;    // byte1 is valid
    logic       last;   // final byte of this entry ends the string
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic idle;         // decoder sits in normal text mode
  } front_status_t;

  // Simple escapes: returns {hit, value}.
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h6E:   r = {1'b1, 8'h0A}; // n
      8'h74:   r = {1'b1, 8'h09}; // t
      8'h72:   r = {1'b1, 8'h0D}; // r
      8'h30:   r = {1'b1, 8'h00}; // 0
      8'h61:   r = {1'b1, 8'h07}; // a
      8'h62:   r = {1'b1, 8'h08}; // b
      8'h66:   r = {1'b1, 8'h0C}; // f
      8'h76:   r = {1'b1, 8'h0B}; // v
      8'h5C:   r = {1'b1, 8'h5C}; // backslash
      8'h27:   r = {1'b1, 8'h27}; // single quote
      8'h22:   r = {1'b1, 8'h22}; // double quote
      default: r = 9'h000;
    endcase
    return r;
  endfunction

  // Hex digit: returns {valid, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_SEVEN);
  endfunction

endpackage

// ===== hw/rtl/cesd_front.sv =====
// ----------------------------------------------------------------------------
// cesd_front: byte classifier and escape state machine
// Takes one raw byte per beat, tracks the escape mode and pushes the one or
// two decoded bytes it produces into the queue as one entry.
// ----------------------------------------------------------------------------
module cesd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  output logic                    push_o,
  output cesd_pkg::entry_t        entry_o,
  output cesd_pkg::front_status_t status_o
);

  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_ESC    = 6'b000010,
    MODE_HEX0   = 6'b000100,
    MODE_HEX1   = 6'b001000,
    MODE_OCT1   = 6'b010000,
    MODE_OCT2   = 6'b100000
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [5:0] acc_q, acc_d;

  always_comb begin
    logic [7:0] ob [2];
    logic [1:0] n;
    logic       used;
    logic [8:0] em;
    logic [4:0] hv;

    ob[0]  = 8'h00;
    ob[1]  = 8'h00;
    n      = 2'd0;
    used   = 1'b1;
    mode_d = MODE_NORMAL;
    acc_d  = 6'd0;
    em     = cesd_pkg::esc_map(byte_i);
    hv     = cesd_pkg::hex_digit(byte_i);

    unique case (mode_q)
      MODE_ESC: begin
        if (em[8]) begin
          ob[n[0]] = em[7:0];
          n = n + 2'd1;
        end else if (byte_i == cesd_pkg::CHR_X) begin
          mode_d = MODE_HEX0;
        end else if (byte_i >= cesd_pkg::CHR_ONE && byte_i <= cesd_pkg::CHR_SEVEN) begin
          acc_d  = {3'b000, byte_i[2:0]};
          mode_d = MODE_OCT1;
        end else begin
          // unknown escape: keep the backslash and the byte
          ob[0] = cesd_pkg::CHR_BACKSLASH;
          ob[1] = byte_i;
          n = 2'd2;
        end
      end
      MODE_HEX0: begin
        if (hv[4]) begin
          acc_d  = {2'b00, hv[3:0]};
          mode_d = MODE_HEX1;
        end else begin
          ob[n[0]] = 8'h00;
          n = n + 2'd1;
          used = 1'b0;
        end
      end
      MODE_HEX1: begin
        if (hv[4]) begin
          ob[n[0]] = {acc_q[3:0], hv[3:0]};
        end else begin
          ob[n[0]] = {2'b00, acc_q};
          used = 1'b0;
        end
        n = n + 2'd1;
      end
      MODE_OCT1: begin
        if (cesd_pkg::is_octal(byte_i)) begin
          acc_d  = {acc_q[2:0], byte_i[2:0]};
          mode_d = MODE_OCT2;
        end else begin
          ob[n[0]] = {2'b00, acc_q};
          n = n + 2'd1;
          used = 1'b0;
        end
      end
      MODE_OCT2: begin
        if (cesd_pkg::is_octal(byte_i)) begin
          ob[n[0]] = {acc_q[4:0], byte_i[2:0]};
        end else begin
          ob[n[0]] = {2'b00, acc_q};
          used = 1'b0;
        end
        n = n + 2'd1;
      end
      default: begin
        used = 1'b0;
      end
    endcase

    // byte not consumed by an escape: treat as ordinary text
    if (!used) begin
      if (byte_i == cesd_pkg::CHR_BACKSLASH) begin
        mode_d = MODE_ESC;
      end else begin
        ob[n[0]] = byte_i;
        n = n + 2'd1;
      end
    end

    // end of string: flush whatever escape is still open
    if (last_i) begin
      unique case (mode_d)
        MODE_ESC: begin
          ob[n[0]] = cesd_pkg::CHR_BACKSLASH;
          n = n + 2'd1;
        end
        MODE_HEX0: begin
          ob[n[0]] = 8'h00;
          n = n + 2'd1;
        end
        MODE_HEX1, MODE_OCT1, MODE_OCT2: begin
          ob[n[0]] = {2'b00, acc_d};
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      mode_d = MODE_NORMAL;
      acc_d  = 6'd0;
    end

    entry_o.byte0 = ob[0];
    entry_o.byte1 = ob[1];
    entry_o.two   = n[1];
    entry_o.last  = last_i;
    push_o        = accept_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= 6'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

  assign status_o.idle = (mode_q == MODE_NORMAL);

endmodule

// ===== hw/rtl/cesd_queue.sv =====
// ----------------------------------------------------------------------------
// cesd_queue: short entry queue between front and back end
// Circular buffer of decoded entries; full and empty come from a registered
// fill count.
// ----------------------------------------------------------------------------
module cesd_queue #(
  parameter int unsigned Depth = cesd_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  cesd_pkg::entry_t        entry_i,
  input  logic                    pop_i,
  output cesd_pkg::entry_t        head_o,
  output cesd_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cesd_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== hw/rtl/cesd_back.sv =====
// ----------------------------------------------------------------------------
// cesd_back: output serializer
// Pops queue entries and drives them out one byte per beat through an output
// register, holding the second byte of a two-byte entry in a spare stage.
// ----------------------------------------------------------------------------
module cesd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cesd_pkg::entry_t        head_i,
  input  cesd_pkg::queue_status_t qstat_i,
  output logic                    pop_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [7:0]              byte_o,
  output logic                    last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       pend_q, pend_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       pend_last_q, pend_last_d;
  logic       load;

  assign load = !valid_q || ready_i;

  always_comb begin
    valid_d     = valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    pend_last_d = pend_last_q;
    pop_o       = 1'b0;
    if (load) begin
      priority if (pend_q) begin
        valid_d = 1'b1;
        byte_d  = pend_byte_q;
        last_d  = pend_last_q;
        pend_d  = 1'b0;
      end else if (!qstat_i.empty) begin
        pop_o       = 1'b1;
        valid_d     = 1'b1;
        byte_d      = head_i.byte0;
        last_d      = head_i.last && !head_i.two;
        pend_d      = head_i.two;
        pend_byte_d = head_i.byte1;
        pend_last_d = head_i.last;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    last_q      <= last_d;
    pend_byte_q <= pend_byte_d;
    pend_last_q <= pend_last_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

// ===== hw/rtl/c_escape_sequence_decoder_core.sv =====
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_core: streaming C string unescaper
// Path: a decoded byte passes the queue entry and then the output register before it shows on m_axis.
// Throughput: one input beat per cycle while the queue has room; a two-byte result goes out as two
// output bytes, so the QueueDepth-entry queue between front and back end fills.
// Reset: asynchronous, active low; returns to normal text mode, empty queue.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_core #(
  parameter int unsigned QueueDepth = cesd_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // raw input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  // decoded output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  logic                    in_accept;
  logic                    push;
  logic                    pop;
  cesd_pkg::entry_t        push_entry;
  cesd_pkg::entry_t        head_entry;
  cesd_pkg::queue_status_t qstat;
  cesd_pkg::front_status_t fstat;

  // Take a beat whenever the queue has room; the front end never stalls
  // otherwise, and bytes that decode to nothing (escape starts) still count.
  assign s_axis_tready = !qstat.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Front end: classify the byte, advance the escape mode, build the entry.
  cesd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .entry_o  (push_entry),
    .status_o (fstat)
  );

  // Decouple decoding from the output side so each can stall on its own.
  cesd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (qstat)
  );

  // Back end: serialize each entry onto the output stream, one beat per byte.
  cesd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .qstat_i (qstat),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  // End of string always produces at least one output byte.
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tlast) |-> push)
    else $error("string end produced no entry");

  // The escape state is cleared after the final beat of a string.
  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tlast) |=> fstat.idle)
    else $error("decoder not idle after string end");

  // A queued entry reaches an idle output register in the next cycle.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!qstat.empty && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("output stalled with entries queued");

endmodule
